// ----- rtl/sstc_pkg.sv -----
// Shared types and constants for the subarray sum target counter.
// No dependencies.
package sstc_pkg;
  localparam int MaxLen       = 1024;
  localparam int TableDepth   = 2048;
  localparam int ElementBits  = 16;
  localparam int SumBits      = 27;
  localparam int TotalBits    = 20;
  localparam int CountBits    = 11;
  localparam int EpochBits    = 8;
  localparam int SlotBits     = $clog2(TableDepth);
  localparam int IndexBits    = $clog2(MaxLen + 1);
  localparam logic [31:0] HashMul = 32'd2654435761;

  typedef logic signed [SumBits-1:0] sum_t;

  typedef struct packed {
    logic start;      // begin item: latch inputs
    logic clear;      // clear table, seed starts
    logic lookup;     // begin probe of key (sum - target)
    logic bump;       // begin probe of current sum
  } sstc_cmd_t;

  typedef struct packed {
    logic busy;       // probe or clear in progress
    logic too_long;
  } sstc_sts_t;

  function automatic logic [SlotBits-1:0] home_slot(input logic [SumBits-1:0] key);
    logic [2*SlotBits-1:0] prod;
    prod = key[SlotBits-1:0] * HashMul[SlotBits-1:0];
    return prod[SlotBits-1:0];
  endfunction
endpackage

// ----- rtl/sstc_stream_if.sv -----
// Valid/ready channel interface for the counter's input and output beats.
// Depends on sstc_pkg.
interface sstc_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [sstc_pkg::ElementBits-1:0] element;
  logic                                  first;
  modport source (output valid, output element, output first, input ready);
  modport sink   (input valid, input element, input first, output ready);
endinterface

interface sstc_out_if;
  logic                                valid;
  logic                                ready;
  logic [sstc_pkg::TotalBits-1:0]      match_total;
  logic                                too_long;
  modport source (output valid, output match_total, output too_long, input ready);
  modport sink   (input valid, input match_total, input too_long, output ready);
endinterface

// ----- rtl/subarray_sum_target_counter.sv -----
// Top level of the subarray sum target counter.
// Depends on sstc_pkg, sstc_stream_if, sstc_ctrl and sstc_datapath.
//
// Usage: in_if carries one signed element per beat with a first flag that
// starts a new sequence (table, sum and total are cleared and sum 0 is
// seeded). out_if returns one beat per input: the running match count and
// a too_long flag for elements past the maximum length, which are ignored.
// target_we_i/target_i write the target sum; the user must write it only
// while the block is idle, which the block itself does not enforce. Each
// result follows a lookup probe and then a bump probe, reading table slots
// one at a time; a first beat first clears and seeds sum 0, and an element
// past the maximum length skips both probes. One memory read port sets the
// probe rate. One item is in flight; in_if is ready again the cycle after
// the result beat is taken, so a stall keeps the block from taking the next
// item. Reset clears sum, total, index and target and starts a pass that
// marks every table slot empty; the same pass runs on every 255th first
// beat, when the sequence tag wraps. Beats wait until it ends.
module subarray_sum_target_counter (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              target_we_i,
  input  logic [sstc_pkg::SumBits-1:0]      target_i,
  sstc_in_if.sink                           in_if,
  sstc_out_if.source                        out_if
);
  import sstc_pkg::*;

  logic [SumBits-1:0] target_q;
  sstc_cmd_t cmd;
  sstc_sts_t sts;
  logic signed [ElementBits-1:0] elem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) target_q <= '0;
    else if (target_we_i) target_q <= target_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd.start) elem_q <= in_if.element;
  end

  sstc_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i     (in_if.valid),
    .in_first_i     (in_if.first),
    .in_ready_o     (in_if.ready),
    .out_valid_o    (out_if.valid),
    .out_ready_i    (out_if.ready),
    .out_too_long_o (out_if.too_long),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  sstc_datapath u_dp (
    .clk_i, .rst_ni,
    .cmd_i     (cmd),
    .element_i (elem_q),
    .target_i  (target_q),
    .sts_o     (sts),
    .total_o   (out_if.match_total)
  );
endmodule

// ----- rtl/sstc_datapath.sv -----
// Datapath: prefix sum, running total, hash table with linear probing.
// Depends on sstc_pkg.
module sstc_datapath (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  sstc_pkg::sstc_cmd_t                    cmd_i,
  input  logic signed [sstc_pkg::ElementBits-1:0] element_i,
  input  logic [sstc_pkg::SumBits-1:0]           target_i,
  output sstc_pkg::sstc_sts_t                    sts_o,
  output logic [sstc_pkg::TotalBits-1:0]         total_o
);
  import sstc_pkg::*;

  typedef enum logic [6:0] {
    P_IDLE  = 7'b0000001,
    P_CLEAR = 7'b0000010,
    P_READ  = 7'b0000100,
    P_CHECK = 7'b0001000,
    P_SEED  = 7'b0010000,
    P_NEXT  = 7'b0100000,
    P_WIPE  = 7'b1000000
  } probe_e;

  probe_e                 pst_q, pst_d;
  logic [SumBits-1:0]     sum_q, key_q;
  logic [TotalBits-1:0]   total_q;
  logic [IndexBits-1:0]   index_q;
  logic [SlotBits-1:0]    slot_q, clr_q;
  logic [SlotBits:0]      tries_q;
  logic                   is_bump_q, seed_q;
  logic [EpochBits-1:0]   epoch_q;
  logic [EpochBits-1:0]   mem_tag [TableDepth];
  logic [SumBits-1:0]     mem_key [TableDepth];
  logic [CountBits-1:0]   mem_cnt [TableDepth];
  logic [EpochBits-1:0]   rd_tag_q;
  logic [SumBits-1:0]     rd_key_q;
  logic [CountBits-1:0]   rd_cnt_q;
  logic                   rd_val;
  logic [SumBits-1:0]     new_sum;
  logic [TotalBits:0]     add_total;

  assign new_sum = sum_q + {{(SumBits-ElementBits){element_i[ElementBits-1]}}, element_i};
  assign add_total = {1'b0, total_q} + {{(TotalBits+1-CountBits){1'b0}}, rd_cnt_q};
  assign rd_val = (rd_tag_q == epoch_q);

  assign sts_o.busy     = (pst_q != P_IDLE);
  assign sts_o.too_long = (index_q >= IndexBits'(MaxLen));
  assign total_o        = total_q;

  always_comb begin
    pst_d = pst_q;
    case (pst_q)
      P_IDLE:  if (cmd_i.clear) pst_d = (epoch_q == '1) ? P_WIPE : P_CLEAR;
               else if (cmd_i.lookup || cmd_i.bump) pst_d = P_READ;
      P_WIPE:  if (clr_q == '1) pst_d = seed_q ? P_CLEAR : P_IDLE;
      P_CLEAR: pst_d = P_SEED;
      P_SEED:  pst_d = P_READ;
      P_READ:  pst_d = P_CHECK;
      P_CHECK: pst_d = P_IDLE;
      P_NEXT:  pst_d = P_READ;
      default: pst_d = P_IDLE;
    endcase
  end

  // a slot is live when its tag matches the current sequence tag
  always_ff @(posedge clk_i) begin
    rd_tag_q <= mem_tag[slot_q];
    rd_key_q <= mem_key[slot_q];
    rd_cnt_q <= mem_cnt[slot_q];
    if (pst_q == P_WIPE) begin
      mem_tag[clr_q] <= '0;
    end else if (pst_q == P_CHECK && is_bump_q) begin
      if (!rd_val) begin
        mem_tag[slot_q] <= epoch_q;
        mem_key[slot_q] <= key_q;
        mem_cnt[slot_q] <= CountBits'(1);
      end else if (rd_key_q == key_q && rd_cnt_q != '1) begin
        mem_cnt[slot_q] <= rd_cnt_q + CountBits'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pst_q     <= P_WIPE;
      sum_q     <= '0;
      total_q   <= '0;
      index_q   <= '0;
      key_q     <= '0;
      slot_q    <= '0;
      clr_q     <= '0;
      tries_q   <= '0;
      is_bump_q <= 1'b0;
      seed_q    <= 1'b0;
      epoch_q   <= EpochBits'(1);
    end else begin
      case (pst_q)
        P_IDLE: begin
          if (cmd_i.clear) begin
            sum_q   <= '0;
            total_q <= '0;
            index_q <= '0;
            if (epoch_q == '1) begin
              epoch_q <= EpochBits'(1);
              seed_q  <= 1'b1;
            end else begin
              epoch_q <= epoch_q + EpochBits'(1);
            end
          end else if (cmd_i.lookup) begin
            sum_q     <= new_sum;
            index_q   <= index_q + IndexBits'(1);
            key_q     <= new_sum - target_i;
            slot_q    <= home_slot(new_sum - target_i);
            tries_q   <= '0;
            is_bump_q <= 1'b0;
          end else if (cmd_i.bump) begin
            key_q     <= sum_q;
            slot_q    <= home_slot(sum_q);
            tries_q   <= '0;
            is_bump_q <= 1'b1;
          end
        end
        P_WIPE: begin
          clr_q <= clr_q + SlotBits'(1);
          if (clr_q == '1) seed_q <= 1'b0;
        end
        P_CLEAR: begin
          key_q     <= '0;
          slot_q    <= home_slot('0);
          tries_q   <= '0;
          is_bump_q <= 1'b1;
        end
        P_CHECK: begin
          if (rd_val && rd_key_q != key_q && tries_q < (SlotBits+1)'(TableDepth - 1)) begin
            pst_q   <= P_NEXT;
            slot_q  <= slot_q + SlotBits'(1);
            tries_q <= tries_q + (SlotBits+1)'(1);
          end else begin
            pst_q <= P_IDLE;
            if (!is_bump_q && rd_val && rd_key_q == key_q)
              total_q <= add_total[TotalBits] ? '1 : add_total[TotalBits-1:0];
          end
        end
        default: ;
      endcase
      if (pst_q != P_CHECK) pst_q <= pst_d;
    end
  end
endmodule

// ----- rtl/sstc_ctrl.sv -----
// Controller: sequences clear, lookup and bump per item, drives handshakes.
// Depends on sstc_pkg.
module sstc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_first_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                out_too_long_o,
  output sstc_pkg::sstc_cmd_t cmd_o,
  input  sstc_pkg::sstc_sts_t sts_i
);
  import sstc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_CLEAR  = 6'b000010,
    S_LOOKUP = 6'b000100,
    S_BUMP   = 6'b001000,
    S_WAIT   = 6'b010000,
    S_OUT    = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   tl_q, tl_d;

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = (state_q == S_OUT);
  assign out_too_long_o = tl_q;

  always_comb begin
    state_d   = state_q;
    tl_d      = tl_q;
    cmd_o     = '0;
    case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.start = 1'b1;
        state_d = in_first_i ? S_CLEAR : S_LOOKUP;
      end
      S_CLEAR: if (!sts_i.busy) begin
        cmd_o.clear = 1'b1;
        state_d = S_LOOKUP;
      end
      S_LOOKUP: if (!sts_i.busy) begin
        if (sts_i.too_long) begin
          tl_d = 1'b1;
          state_d = S_OUT;
        end else begin
          tl_d = 1'b0;
          cmd_o.lookup = 1'b1;
          state_d = S_BUMP;
        end
      end
      S_BUMP: if (!sts_i.busy) begin
        cmd_o.bump = 1'b1;
        state_d = S_WAIT;
      end
      S_WAIT: if (!sts_i.busy) state_d = S_OUT;
      S_OUT:  if (out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      tl_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      tl_q    <= tl_d;
    end
  end
endmodule
